// ===== rtl/core/vtpl_pkg.sv =====
// vtpl_pkg: shared types and constants of the vertex transform and projection block
// holds operation codes, controller states and the command and status words
// no dependencies
package vtpl_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FRAME  = 2'd1;
    localparam logic [1:0] OP_VERTEX = 2'd2;

    localparam logic [3:0] NUM_COEF    = 4'd9;
    localparam logic [3:0] SLOT_VIEW_X = 4'd9;
    localparam logic [3:0] SLOT_VIEW_Z = 4'd11;

    localparam logic [1:0] LAST_ROW = 2'd2;
    localparam logic [1:0] LAST_COL = 2'd2;

    localparam int DIGIT_BITS  = 8;
    localparam int QUOT_BITS   = 9;
    localparam int SCREEN_BITS = 10;
    localparam logic [3:0] LAST_DIV_STEP = 4'(QUOT_BITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       frame;
        logic       start;
        logic       mul;
        logic       acc;
        logic       check;
        logic       div;
        logic       emit;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] chunk;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/vertex_transform_project_lines.sv =====
// vertex_transform_project_lines: top level of the vertex transform and projection block
// joins the controller and the datapath
// depends on vtpl_pkg, vtpl_ctrl, vtpl_dp
//
// Load and frame-start words are taken in the idle state without leaving it. A vertex
// word holds the input from its acceptance until its result is loaded into the output
// register: each of the nine matrix terms goes through one shared multiplier an 8-bit
// coefficient digit per cycle plus an accumulate step, then a depth test step, nine
// restoring divide steps that produce both screen coordinates side by side and an
// output step that loads the output register. While an earlier result is still held
// there by out_stall, the controller waits in its output state and the vertex word
// holds the input longer. A finished result waits in the output register while the
// next word is taken in.
module vertex_transform_project_lines #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [3:0]         slot_index,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               visible,
    output logic               draw_segment,
    output logic signed [9:0]  start_x,
    output logic signed [9:0]  start_y,
    output logic signed [9:0]  end_x,
    output logic signed [9:0]  end_y
);

    vtpl_pkg::cmd_t    cmd;
    vtpl_pkg::status_t status;

    vtpl_ctrl #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .status    (status)
    );

    vtpl_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .slot_index   (slot_index),
        .load_value   (load_value),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .visible      (visible),
        .draw_segment (draw_segment),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y)
    );

endmodule

// ===== rtl/core/vtpl_ctrl.sv =====
// vtpl_ctrl: sequencing state machine of the vertex transform block
// steps the digit multiplier over the nine matrix terms, then the divider
// depends on vtpl_pkg
module vtpl_ctrl #(
    parameter int COEF_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        operation,
    output logic              in_stall,
    output vtpl_pkg::cmd_t    cmd,
    input  vtpl_pkg::status_t status
);

    localparam int NCH = (COEF_WIDTH + vtpl_pkg::DIGIT_BITS - 1) / vtpl_pkg::DIGIT_BITS;
    localparam logic [1:0] LAST_CHUNK = 2'(NCH - 1);

    vtpl_pkg::state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] chunk_reg, chunk_next;
    logic [3:0] div_reg, div_next;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        chunk_next = chunk_reg;
        div_next   = div_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.chunk  = chunk_reg;
        case (state_reg)
            vtpl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        vtpl_pkg::OP_LOAD:  cmd.load  = 1'b1;
                        vtpl_pkg::OP_FRAME: cmd.frame = 1'b1;
                        vtpl_pkg::OP_VERTEX:
                        begin
                            cmd.start  = 1'b1;
                            row_next   = '0;
                            col_next   = '0;
                            chunk_next = '0;
                            state_next = vtpl_pkg::ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            vtpl_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (chunk_reg == LAST_CHUNK)
                    state_next = vtpl_pkg::ST_ACC;
                else
                    chunk_next = chunk_reg + 2'd1;
            end
            vtpl_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                chunk_next = '0;
                state_next = vtpl_pkg::ST_MUL;
                if (col_reg == vtpl_pkg::LAST_COL)
                begin
                    if (row_reg == vtpl_pkg::LAST_ROW)
                    begin
                        state_next = vtpl_pkg::ST_CHECK;
                    end
                    else
                    begin
                        col_next = '0;
                        row_next = row_reg + 2'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            vtpl_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                div_next   = '0;
                state_next = vtpl_pkg::ST_DIV;
            end
            vtpl_pkg::ST_DIV:
            begin
                cmd.div = 1'b1;
                if (div_reg == vtpl_pkg::LAST_DIV_STEP)
                    state_next = vtpl_pkg::ST_OUT;
                else
                    div_next = div_reg + 4'd1;
            end
            vtpl_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = vtpl_pkg::ST_IDLE;
                end
            end
            default: state_next = vtpl_pkg::ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != vtpl_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtpl_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            chunk_reg <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            chunk_reg <= chunk_next;
            div_reg   <= div_next;
        end
    end

    a_vertex_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vtpl_pkg::ST_IDLE && in_valid && operation == vtpl_pkg::OP_VERTEX)
        |=> state_reg == vtpl_pkg::ST_MUL)
        else $error("vertex word did not start the multiply sequence");

    a_check_after_last_term: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |-> (row_reg == vtpl_pkg::LAST_ROW && col_reg == vtpl_pkg::LAST_COL))
        else $error("depth check before all matrix terms were summed");

    a_term_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg != 2'd3 && col_reg != 2'd3 && chunk_reg <= LAST_CHUNK))
        else $error("term index out of range");

endmodule

// ===== rtl/core/vtpl_dp.sv =====
// vtpl_dp: datapath of the vertex transform block
// matrix and viewer store, digit multiplier, depth test, two-lane divider, output word
// depends on vtpl_pkg
module vtpl_dp #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  vtpl_pkg::cmd_t           cmd,
    output vtpl_pkg::status_t        status,
    input  logic [3:0]               slot_index,
    input  logic signed [31:0]       load_value,
    input  logic signed [31:0]       point_x,
    input  logic signed [31:0]       point_y,
    input  logic signed [31:0]       point_z,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic                     visible,
    output logic                     draw_segment,
    output logic signed [9:0]        start_x,
    output logic signed [9:0]        start_y,
    output logic signed [9:0]        end_x,
    output logic signed [9:0]        end_y
);

    localparam int W   = COORD_WIDTH;
    localparam int C   = COEF_WIDTH;
    localparam int F   = C - 2;
    localparam int RW  = W + 1;
    localparam int PW  = RW + C;
    localparam int SW  = W + 2;
    localparam int DW  = W + 4;
    localparam int NW  = DW + 10;
    localparam int QB  = vtpl_pkg::QUOT_BITS;
    localparam int SB  = vtpl_pkg::SCREEN_BITS;
    localparam int DB  = vtpl_pkg::DIGIT_BITS;
    localparam int NCH = (C + DB - 1) / DB;
    localparam int CPW = NCH * DB;
    localparam int DSW = DW + QB - 1;

    logic signed [C-1:0]  coef_reg [9];
    logic signed [W-1:0]  view_reg [3];
    logic                 pen_reg;
    logic signed [SB-1:0] prev_x_reg, prev_y_reg;

    logic signed [RW-1:0] rel_reg [3];
    logic                 zero_reg;
    logic [PW-1:0]        prod_reg;
    logic signed [DW-1:0] acc_reg [3];
    logic                 clip_reg;
    logic                 neg_y_reg, neg_z_reg;
    logic [NW-1:0]        rem_y_reg, rem_z_reg;
    logic [DSW-1:0]       dsh_reg;
    logic [QB-1:0]        quot_y_reg, quot_z_reg;

    logic                 out_valid_reg;
    logic                 visible_reg, draw_reg;
    logic signed [SB-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    // vertex entry
    logic signed [W-1:0]   wx, wy, wz;
    logic signed [W+1:0]   wsum;
    assign wx   = W'(point_x);
    assign wy   = W'(point_y);
    assign wz   = W'(point_z);
    assign wsum = (W+2)'(wx) + (W+2)'(wy) + (W+2)'(wz);

    // digit multiply
    logic [3:0]           coef_idx;
    logic signed [C-1:0]  coef_sel;
    logic signed [RW-1:0] rel_sel;
    logic                 cneg, rneg, neg;
    logic [C-1:0]         cmag;
    logic [CPW-1:0]       cpad;
    logic [RW-1:0]        rmag;
    logic [DB-1:0]        digit;
    logic [RW+DB-1:0]     part;
    logic [PW-1:0]        prod_next;
    logic [4:0]           shamt;

    assign coef_idx = 4'({cmd.row, 1'b0}) + 4'(cmd.row) + 4'(cmd.col);

    always_comb
    begin
        coef_sel = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (coef_idx == 4'(i))
                coef_sel = coef_reg[i];
        end
        case (cmd.col)
            2'd0:    rel_sel = rel_reg[0];
            2'd1:    rel_sel = rel_reg[1];
            default: rel_sel = rel_reg[2];
        endcase
    end

    assign cneg  = coef_sel[C-1];
    assign rneg  = rel_sel[RW-1];
    assign neg   = cneg ^ rneg;
    assign cmag  = cneg ? ($unsigned(~coef_sel) + 1'b1) : $unsigned(coef_sel);
    assign rmag  = rneg ? ($unsigned(~rel_sel) + 1'b1) : $unsigned(rel_sel);
    assign cpad  = CPW'(cmag);
    assign digit = cpad[cmd.chunk * DB +: DB];
    assign part  = (RW+DB)'(rmag) * (RW+DB)'(digit);
    assign shamt = 5'({cmd.chunk, 3'b000});
    assign prod_next = ((cmd.chunk == 2'd0) ? '0 : prod_reg) + (PW'(part) << shamt);

    // term accumulate
    logic [SW-1:0]        scaled;
    logic signed [DW-1:0] mag_s, term;
    logic signed [DW-1:0] acc_sel;
    assign scaled = SW'(prod_reg >> F);
    assign mag_s  = $signed(DW'(scaled));
    assign term   = neg ? -mag_s : mag_s;

    always_comb
    begin
        case (cmd.row)
            2'd0:    acc_sel = acc_reg[0];
            2'd1:    acc_sel = acc_reg[1];
            default: acc_sel = acc_reg[2];
        endcase
    end

    // depth test and numerators
    logic signed [DW-1:0] dx, dy, dz, ady, adz;
    logic signed [NW-1:0] ny, nz;
    logic                 clip_next;
    assign dx  = acc_reg[0];
    assign dy  = acc_reg[1];
    assign dz  = acc_reg[2];
    assign ady = dy[DW-1] ? -dy : dy;
    assign adz = dz[DW-1] ? -dz : dz;
    assign ny  = (NW'(dy) <<< 8) + (NW'(dy) <<< 7) + (NW'(dx) <<< 6);
    assign nz  = (NW'(dz) <<< 8) + (NW'(dz) <<< 7) + (NW'(dx) <<< 6);
    assign clip_next = zero_reg || (dx == '0) || (dx < ady) || (dx < adz);

    // restoring divide step
    logic [NW-1:0] dsh_ext;
    logic          take_y, take_z;
    assign dsh_ext = NW'(dsh_reg);
    assign take_y  = (rem_y_reg >= dsh_ext);
    assign take_z  = (rem_z_reg >= dsh_ext);

    // projected point
    logic signed [SB-1:0] qy_s, qz_s, ex, ey;
    assign qy_s = $signed(SB'(quot_y_reg));
    assign qz_s = $signed(SB'(quot_z_reg));
    assign ex   = neg_y_reg ? -qy_s : qy_s;
    assign ey   = neg_z_reg ? -qz_s : qz_s;

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                coef_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                view_reg[i] <= '0;
            pen_reg       <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    if (slot_index == 4'(i))
                        coef_reg[i] <= load_value[C-1:0];
                end
                for (int i = 0; i < 3; i++)
                begin
                    if (slot_index == vtpl_pkg::SLOT_VIEW_X + 4'(i))
                        view_reg[i] <= W'(load_value);
                end
            end
            if (cmd.frame)
                pen_reg <= 1'b0;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (clip_reg)
                begin
                    pen_reg <= 1'b0;
                end
                else
                begin
                    pen_reg    <= 1'b1;
                    prev_x_reg <= ex;
                    prev_y_reg <= ey;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rel_reg[0] <= RW'(wx) - RW'(view_reg[0]);
            rel_reg[1] <= RW'(wy) - RW'(view_reg[1]);
            rel_reg[2] <= RW'(wz) + RW'(view_reg[2]);
            zero_reg   <= (wsum == '0);
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cmd.row == 2'(i))
                    acc_reg[i] <= ((cmd.col == 2'd0) ? '0 : acc_sel) + term;
            end
        end
        if (cmd.check)
        begin
            clip_reg   <= clip_next;
            neg_y_reg  <= ny[NW-1];
            neg_z_reg  <= nz[NW-1];
            rem_y_reg  <= ny[NW-1] ? $unsigned(-ny) : $unsigned(ny);
            rem_z_reg  <= nz[NW-1] ? $unsigned(-nz) : $unsigned(nz);
            dsh_reg    <= DSW'($unsigned(dx)) << (QB - 1);
            quot_y_reg <= '0;
            quot_z_reg <= '0;
        end
        if (cmd.div)
        begin
            if (take_y)
                rem_y_reg <= rem_y_reg - dsh_ext;
            if (take_z)
                rem_z_reg <= rem_z_reg - dsh_ext;
            quot_y_reg <= {quot_y_reg[QB-2:0], take_y};
            quot_z_reg <= {quot_z_reg[QB-2:0], take_z};
            dsh_reg    <= dsh_reg >> 1;
        end
        if (cmd.emit)
        begin
            visible_reg <= !clip_reg;
            draw_reg    <= !clip_reg && pen_reg;
            start_x_reg <= (!clip_reg && pen_reg) ? prev_x_reg : '0;
            start_y_reg <= (!clip_reg && pen_reg) ? prev_y_reg : '0;
            end_x_reg   <= clip_reg ? '0 : ex;
            end_y_reg   <= clip_reg ? '0 : ey;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visible      = visible_reg;
    assign draw_segment = draw_reg;
    assign start_x      = start_x_reg;
    assign start_y      = start_y_reg;
    assign end_x        = end_x_reg;
    assign end_y        = end_y_reg;

    a_visible_lowers_pen: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !clip_reg) |=> (pen_reg && visible_reg))
        else $error("visible vertex did not put the pen down");

    a_no_segment_when_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !visible_reg) |-> !draw_reg)
        else $error("segment drawn to a clipped vertex");

    a_frame_lifts_pen: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.frame && !cmd.emit) |=> !pen_reg)
        else $error("frame start left the pen down");

endmodule
